// ===== rtl/cartridge_bank_mapper_core_macros.svh =====
`ifndef CARTRIDGE_BANK_MAPPER_CORE_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_MACROS_SVH

// same-cycle implication on clk_i, off during reset
`define CBM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbm assertion failed");

// next-cycle implication on clk_i, off during reset
`define CBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

`endif

// ===== rtl/cbm_pkg.sv =====
package cbm_pkg;

  typedef enum logic [1:0] {
    OP_CPU_RD = 2'd0,
    OP_CPU_WR = 2'd1,
    OP_PPU_RD = 2'd2,
    OP_PPU_WR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_CHR_RAM = 3'd4
  } tgt_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    tgt_e        target;
    logic [21:0] mapped_address;
    logic [7:0]  fixed_value;
    logic        write_enable;
    logic [7:0]  write_out;
    logic [1:0]  mirror_out;
    logic        ram_dirty;
  } out_item_t;

  // register indexes
  localparam logic [2:0] REG_PRG_ROM_LOG2  = 3'd0;
  localparam logic [2:0] REG_CHR_ROM_LOG2  = 3'd1;
  localparam logic [2:0] REG_CHR_IS_RAM    = 3'd2;
  localparam logic [2:0] REG_CHR_RAM_LOG2  = 3'd3;
  localparam logic [2:0] REG_PRG_RAM_BYTES = 3'd4;
  localparam logic [2:0] REG_INIT_MIRROR   = 3'd5;

  // bank register pages, address bits 15:12
  localparam logic [3:0] PAGE_PRG_SEL = 4'h8;
  localparam logic [3:0] PAGE_MIRROR  = 4'h9;
  localparam logic [3:0] PAGE_PROTECT = 4'hA;
  localparam logic [3:0] PAGE_CHR_SEL = 4'hB;

  localparam logic [15:0] RAM_BASE  = 16'h6000;
  localparam logic [15:0] ROM_BASE  = 16'h8000;
  localparam logic [15:0] CHR_LIMIT = 16'h2000;

  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd0;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd1;

  localparam logic [1:0] PROTECT_WR_OK = 2'b10;
  localparam logic [7:0] OPEN_BUS      = 8'hFF;

endpackage

// ===== rtl/cartridge_bank_mapper_core.sv =====
// results are registered; a stalled output sends them to the skid register
// throughput: one transaction per cycle; the two-entry output stage (result
//   register plus skid register) lets input and output stall independently
// in_stall_o rises only when both output entries are full
// reset: asynchronous, active low; bank and protect cleared, mirror set to
//   vertical, configuration registers back to defaults, output stage empty
module cartridge_bank_mapper_core #(
  parameter int MaxPrgBanksLog2 = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cbm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbm_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cbm_pkg::*;

  localparam int BankW = (MaxPrgBanksLog2 > 4) ? MaxPrgBanksLog2 : 4;
  localparam int OffW  = 14 + BankW;

  // configuration
  logic [3:0]  prg_log2_q, chr_log2_q, chr_ram_log2_q;
  logic        chr_is_ram_q;
  logic [13:0] prg_ram_bytes_q;
  logic [1:0]  init_mirror_q;

  // bank state
  logic [3:0] prg_sel_q, prg_sel_d;
  logic [1:0] chr_sel_q, chr_sel_d;
  logic [7:0] protect_q, protect_d;
  logic [1:0] mirror_q, mirror_d;

  // output stage
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  out_item_t res;

  logic cfg_wr, in_fire, out_fire;

  logic [3:0]       prg_lg;
  logic [BankW-1:0] rom_page;
  logic [OffW-1:0]  prg_off, prg_mask;
  logic [14:0]      chr_off, chr_mask;
  logic [12:0]      chr_ram_mask;
  logic [15:0]      addr;
  logic [12:0]      ram_off;
  logic             ram_in_range;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_valid_q && !out_stall_i;

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_PRG_ROM_LOG2:  prdata = 32'(prg_log2_q);
      REG_CHR_ROM_LOG2:  prdata = 32'(chr_log2_q);
      REG_CHR_IS_RAM:    prdata = 32'(chr_is_ram_q);
      REG_CHR_RAM_LOG2:  prdata = 32'(chr_ram_log2_q);
      REG_PRG_RAM_BYTES: prdata = 32'(prg_ram_bytes_q);
      REG_INIT_MIRROR:   prdata = 32'(init_mirror_q);
      default:           prdata = '0;
    endcase
  end

  // address translation
  assign addr    = in_data_i.bus_address;
  assign ram_off = addr[12:0];
  assign ram_in_range = {1'b0, ram_off} < prg_ram_bytes_q;

  assign prg_lg = (prg_log2_q > 4'(MaxPrgBanksLog2)) ? 4'(MaxPrgBanksLog2) : prg_log2_q;
  assign rom_page = (addr[15:14] == 2'b11)
                    ? ((BankW'(1) << prg_lg) - BankW'(1))
                    : BankW'(prg_sel_q);
  assign prg_off  = {rom_page, addr[13:0]};
  assign prg_mask = ~({OffW{1'b1}} << (5'(prg_lg) + 5'd14));

  assign chr_off      = {chr_sel_q, addr[12:0]};
  assign chr_mask     = ~(15'h7FFF << (5'(chr_log2_q) + 5'd13));
  assign chr_ram_mask = ~(13'h1FFF << chr_ram_log2_q);

  always_comb begin
    res        = '0;
    res.target = TGT_NONE;
    prg_sel_d  = prg_sel_q;
    chr_sel_d  = chr_sel_q;
    protect_d  = protect_q;
    mirror_d   = mirror_q;
    unique case (in_data_i.opcode)
      OP_CPU_RD: begin
        if (addr < RAM_BASE) begin
          res.fixed_value = '0;
        end else if (addr < ROM_BASE) begin
          if (!protect_q[7] || !ram_in_range) begin
            res.fixed_value = OPEN_BUS;
          end else begin
            res.target         = TGT_PRG_RAM;
            res.mapped_address = 22'(ram_off);
          end
        end else begin
          res.target         = TGT_PRG_ROM;
          res.mapped_address = 22'(prg_off & prg_mask);
        end
      end
      OP_CPU_WR: begin
        if (addr >= RAM_BASE && addr < ROM_BASE) begin
          if (protect_q[7:6] == PROTECT_WR_OK && ram_in_range) begin
            res.target         = TGT_PRG_RAM;
            res.mapped_address = 22'(ram_off);
            res.write_enable   = 1'b1;
            res.write_out      = in_data_i.write_byte;
            res.ram_dirty      = 1'b1;
          end
        end else if (addr >= ROM_BASE) begin
          unique case (addr[15:12])
            PAGE_PRG_SEL: prg_sel_d = in_data_i.write_byte[3:0];
            PAGE_MIRROR:  mirror_d = in_data_i.write_byte[0] ? MIRROR_HORIZONTAL
                                                             : MIRROR_VERTICAL;
            PAGE_PROTECT: protect_d = in_data_i.write_byte;
            PAGE_CHR_SEL: chr_sel_d = in_data_i.write_byte[1:0];
            default: ;
          endcase
        end
      end
      OP_PPU_RD: begin
        if (addr < CHR_LIMIT) begin
          if (chr_is_ram_q) begin
            res.target         = TGT_CHR_RAM;
            res.mapped_address = 22'(addr[12:0] & chr_ram_mask);
          end else begin
            res.target         = TGT_CHR_ROM;
            res.mapped_address = 22'(chr_off & chr_mask);
          end
        end
      end
      OP_PPU_WR: begin
        if (addr < CHR_LIMIT && chr_is_ram_q) begin
          res.target         = TGT_CHR_RAM;
          res.mapped_address = 22'(addr[12:0] & chr_ram_mask);
          res.write_enable   = 1'b1;
          res.write_out      = in_data_i.write_byte;
        end
      end
      default: ;
    endcase
    res.mirror_out = mirror_d;
  end

  // configuration and bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_log2_q      <= 4'd1;
      chr_log2_q      <= 4'd0;
      chr_is_ram_q    <= 1'b0;
      chr_ram_log2_q  <= 4'd13;
      prg_ram_bytes_q <= 14'd8192;
      init_mirror_q   <= MIRROR_VERTICAL;
      prg_sel_q       <= '0;
      chr_sel_q       <= '0;
      protect_q       <= '0;
      mirror_q        <= MIRROR_VERTICAL;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_PRG_ROM_LOG2:  prg_log2_q      <= pwdata[3:0];
        REG_CHR_ROM_LOG2:  chr_log2_q      <= pwdata[3:0];
        REG_CHR_IS_RAM:    chr_is_ram_q    <= pwdata[0];
        REG_CHR_RAM_LOG2:  chr_ram_log2_q  <= pwdata[3:0];
        REG_PRG_RAM_BYTES: prg_ram_bytes_q <= pwdata[13:0];
        REG_INIT_MIRROR: begin
          init_mirror_q <= pwdata[1:0];
          mirror_q      <= pwdata[1:0];
        end
        default: ;
      endcase
    end else if (in_fire) begin
      prg_sel_q <= prg_sel_d;
      chr_sel_q <= chr_sel_d;
      protect_q <= protect_d;
      mirror_q  <= mirror_d;
    end
  end

  // output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

// ===== rtl/cbm_checker.sv =====
`include "cartridge_bank_mapper_core_macros.svh"

module cbm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cbm_pkg::out_item_t out_data_o
);
  import cbm_pkg::*;

  tgt_e tgt;
  logic ram_tgt;
  logic prg_ram_wr;

  assign tgt        = out_data_o.target;
  assign ram_tgt    = (tgt == TGT_PRG_RAM) || (tgt == TGT_CHR_RAM);
  assign prg_ram_wr = (tgt == TGT_PRG_RAM) && out_data_o.write_enable;

  `CBM_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

  `CBM_ASSERT_IMPL(a_we_target, out_valid_o && out_data_o.write_enable, ram_tgt)

  `CBM_ASSERT_IMPL(a_dirty_ram, out_valid_o && out_data_o.ram_dirty, prg_ram_wr)

  `CBM_ASSERT_IMPL(a_fixed_none, out_valid_o && tgt != TGT_NONE, out_data_o.fixed_value == '0)

  `CBM_ASSERT_IMPL(a_stall_full, in_stall_o, out_valid_o)

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
